[design/stp_pkg.sv]
// ----------------------------------------------------------------------------
// stp_pkg
// Shared widths, trig constants and register codes for the sine-tangent
// projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  // Intermediate magnitudes saturate at 2^INNER_W - 1.
  localparam int INNER_W      = 62;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_MAG_W   = 31;
  localparam int CORDIC_STEPS = 31;
  localparam int TRIG_LAT     = CORDIC_STEPS + 5;
  localparam int DIV_LAT      = INNER_W + 2;

  // 1/(2*pi) in Q0.64, split into two 32-bit halves.
  localparam logic [31:0] INV_2PI_HI = 32'h28BE60DB;
  localparam logic [31:0] INV_2PI_LO = 32'h9391054A;

  localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
  };

  typedef enum logic [1:0] {
    REG_X_SCALE   = 2'd0,
    REG_Y_SCALE   = 2'd1,
    REG_LAT_SCALE = 2'd2,
    REG_TAN_MODE  = 2'd3
  } reg_idx_t;

  localparam int X_SCALE_RST   = 241591561;
  localparam int Y_SCALE_RST   = 403963149;
  localparam int LAT_SCALE_RST = 198196634;

endpackage

`default_nettype wire

[design/sine_tangent_projection_forward.sv]
// ----------------------------------------------------------------------------
// sine_tangent_projection_forward
// Forward general sine-tangent pseudocylindrical projection in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one item per clock while the output is not stalled and
// returns results in order; the rate comes from two fully pipelined 31-step
// CORDIC units and a divider that develops one quotient bit per stage over
// 62 stages. The whole pipeline advances together and holds while a finished
// result waits at the output, so in_ready falls only then. There is no
// clearing pass after reset. The user must write coefficients and mode through
// the cfg_ port only while no item is in flight; the block does not enforce it.
`default_nettype none

module sine_tangent_projection_forward #(
  parameter int FRAC_BITS = 28,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] in_longitude,
  input  logic signed [WORD_BITS-1:0] in_latitude,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_proj_x,
  output logic signed [WORD_BITS-1:0] out_proj_y,
  output logic                        out_overflow,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [WORD_BITS-2:0]        cfg_wdata
);
  import stp_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int IW    = INNER_W;
  localparam int TM    = TRIG_MAG_W;
  localparam int CW    = CORDIC_W;
  localparam int TF    = TRIG_FRAC;
  localparam int MPW   = 2 * W - 1;
  localparam int X1FW  = MPW + 1 - F;
  localparam int X1W   = (X1FW < IW) ? X1FW : IW;
  localparam int X2PW  = X1W + TM;
  localparam int X2FW  = X2PW + 1 - TF;
  localparam int X2W   = (X2FW < IW) ? X2FW : IW;
  localparam int C2PW  = 2 * TM;
  localparam int C2W   = C2PW + 1 - TF;
  localparam int YPW   = W - 1 + TM;
  localparam int Y1W   = YPW + 1 - TF;
  localparam int PXPW  = X2W + C2W;
  localparam int PXFW  = PXPW + 1 - TF;
  localparam int PXW   = (PXFW < IW) ? PXFW : IW;
  localparam int NMW   = (X2W > Y1W) ? X2W : Y1W;
  localparam int OTHW  = (PXW > Y1W) ? PXW : Y1W;
  localparam int ODL   = DIV_LAT - 2;
  localparam int LAST  = TRIG_LAT + DIV_LAT + 5;

  // Configuration registers.
  logic [W-2:0] x_scale_r, y_scale_r, lat_scale_r;
  logic         tan_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r   <= (W-1)'(X_SCALE_RST);
      y_scale_r   <= (W-1)'(Y_SCALE_RST);
      lat_scale_r <= (W-1)'(LAT_SCALE_RST);
      tan_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_X_SCALE:   x_scale_r   <= cfg_wdata;
        REG_Y_SCALE:   y_scale_r   <= cfg_wdata;
        REG_LAT_SCALE: lat_scale_r <= cfg_wdata;
        REG_TAN_MODE:  tan_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together.
  logic            adv;
  logic [LAST:0]   valid_r;

  assign adv       = !valid_r[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[LAST-1:0], in_valid};
    end
  end

  function automatic logic [TM-1:0] trig_mag(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] a;
    a = v[CW-1] ? -v : v;
    return a[TM-1:0];
  endfunction

  // Stage 0: input registers.
  logic signed [W-1:0] lon_r, lat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_r <= in_longitude;
      lat_r <= in_latitude;
    end
  end

  // Stage 1: scale products.
  logic [W-1:0]   lon_mag, lat_mag;
  logic [MPW-1:0] x1p_r, php_r;
  logic           x1_neg_r1, lat_neg_r1;
  logic [W-1:0]   lat_mag_r1;

  assign lon_mag = lon_r[W-1] ? W'(-lon_r) : W'(lon_r);
  assign lat_mag = lat_r[W-1] ? W'(-lat_r) : W'(lat_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1p_r      <= MPW'(x_scale_r) * MPW'(lon_mag);
      php_r      <= MPW'(lat_scale_r) * MPW'(lat_mag);
      x1_neg_r1  <= lon_r[W-1];
      lat_neg_r1 <= lat_r[W-1];
      lat_mag_r1 <= lat_mag;
    end
  end

  // Stage 2: round and saturate x1 and the scaled latitude.
  logic [MPW:0]    x1_rnd, ph_rnd;
  logic [X1FW-1:0] x1_shf, ph_shf;
  logic            x1_ovf, ph_ovf;
  logic [X1W-1:0]  x1_r, phs_r;
  logic            x1_neg_r2, lat_neg_r2, ovf_r2;
  logic [W-1:0]    lat_mag_r2;

  assign x1_rnd = (MPW+1)'(x1p_r) + ((MPW+1)'(1) << (F-1));
  assign ph_rnd = (MPW+1)'(php_r) + ((MPW+1)'(1) << (F-1));
  assign x1_shf = X1FW'(x1_rnd >> F);
  assign ph_shf = X1FW'(ph_rnd >> F);
  assign x1_ovf = |(x1_shf >> IW);
  assign ph_ovf = |(ph_shf >> IW);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r       <= x1_ovf ? '1 : X1W'(x1_shf);
      phs_r      <= ph_ovf ? '1 : X1W'(ph_shf);
      x1_neg_r2  <= x1_neg_r1;
      lat_neg_r2 <= lat_neg_r1;
      lat_mag_r2 <= lat_mag_r1;
      ovf_r2     <= x1_ovf | ph_ovf;
    end
  end

  // Trig of the latitude and of the scaled latitude.
  logic signed [CW-1:0] cphi, sphi, cpr, spr;

  stp_trig #(.AMW(W), .FRAC_BITS(F)) u_trig_lat (
    .clk     (clk),
    .en      (adv),
    .ang_mag (lat_mag_r2),
    .ang_neg (lat_neg_r2),
    .cos_o   (cphi),
    .sin_o   (sphi)
  );

  stp_trig #(.AMW(X1W), .FRAC_BITS(F)) u_trig_phs (
    .clk     (clk),
    .en      (adv),
    .ang_mag (phs_r),
    .ang_neg (x1_neg_r2 ^ x1_neg_r2 ^ lat_neg_r2),
    .cos_o   (cpr),
    .sin_o   (spr)
  );

  // x1 waits for the trig results.
  logic [X1W-1:0] xd_mag_r [TRIG_LAT];
  logic           xd_neg_r [TRIG_LAT];
  logic           xd_ovf_r [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      xd_mag_r[0] <= x1_r;
      xd_neg_r[0] <= x1_neg_r2;
      xd_ovf_r[0] <= ovf_r2;
      for (int k = 1; k < TRIG_LAT; k++) begin
        xd_mag_r[k] <= xd_mag_r[k-1];
        xd_neg_r[k] <= xd_neg_r[k-1];
        xd_ovf_r[k] <= xd_ovf_r[k-1];
      end
    end
  end

  // P1: products with the trig values.
  logic [TM-1:0]   cphi_m, c_m, s_m;
  logic [X2PW-1:0] x2p_r;
  logic [C2PW-1:0] ccp_r;
  logic [YPW-1:0]  ysp_r;
  logic [TM-1:0]   cm_r1;
  logic            x2_neg_r1, y_neg_r1, c_neg_r1, ovf_p1;

  assign cphi_m = trig_mag(cphi);
  assign c_m    = trig_mag(cpr);
  assign s_m    = trig_mag(spr);

  always_ff @(posedge clk) begin
    if (adv) begin
      x2p_r     <= X2PW'(xd_mag_r[TRIG_LAT-1]) * X2PW'(cphi_m);
      ccp_r     <= C2PW'(c_m) * C2PW'(c_m);
      ysp_r     <= YPW'(y_scale_r) * YPW'(s_m);
      x2_neg_r1 <= xd_neg_r[TRIG_LAT-1] ^ cphi[CW-1];
      y_neg_r1  <= spr[CW-1];
      c_neg_r1  <= cpr[CW-1];
      cm_r1     <= c_m;
      ovf_p1    <= xd_ovf_r[TRIG_LAT-1];
    end
  end

  // Unused sine of the plain latitude is an output of the latitude trig unit.
  logic sphi_unused;
  assign sphi_unused = ^sphi;

  // P2: round the products.
  logic [X2PW:0]   x2_rnd;
  logic [X2FW-1:0] x2_shf;
  logic            x2_ovf;
  logic [C2PW:0]   c2_rnd;
  logic [YPW:0]    y1_rnd;
  logic [X2W-1:0]  x2_r;
  logic [C2W-1:0]  c2_r;
  logic [Y1W-1:0]  y1_r;
  logic [TM-1:0]   cm_r2;
  logic            x2_neg_r2, y_neg_r2, c_neg_r2, ovf_p2;

  assign x2_rnd = (X2PW+1)'(x2p_r) + ((X2PW+1)'(1) << (TF-1));
  assign x2_shf = X2FW'(x2_rnd >> TF);
  assign x2_ovf = |(x2_shf >> IW);
  assign c2_rnd = (C2PW+1)'(ccp_r) + ((C2PW+1)'(1) << (TF-1));
  assign y1_rnd = (YPW+1)'(ysp_r) + ((YPW+1)'(1) << (TF-1));

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r      <= x2_ovf ? '1 : X2W'(x2_shf);
      c2_r      <= C2W'(c2_rnd >> TF);
      y1_r      <= Y1W'(y1_rnd >> TF);
      cm_r2     <= cm_r1;
      x2_neg_r2 <= x2_neg_r1;
      y_neg_r2  <= y_neg_r1;
      c_neg_r2  <= c_neg_r1;
      ovf_p2    <= ovf_p1 | x2_ovf;
    end
  end

  // Divider: y over c in tangent form, x over c in sine form.
  logic [IW-1:0] quo_mag;
  logic          quo_neg, quo_ovf;

  stp_div #(.NMW(NMW)) u_div (
    .clk     (clk),
    .en      (adv),
    .num_mag (tan_mode_r ? NMW'(y1_r) : NMW'(x2_r)),
    .num_neg (tan_mode_r ? y_neg_r2 : x2_neg_r2),
    .den_mag (cm_r2),
    .den_neg (c_neg_r2),
    .quo_mag (quo_mag),
    .quo_neg (quo_neg),
    .quo_ovf (quo_ovf)
  );

  // P3: x2 * c2 for the tangent form.
  logic [PXPW-1:0] pxp_r;
  logic [Y1W-1:0]  y1_r3;
  logic            px_neg_r3, y_neg_r3, ovf_p3;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxp_r     <= PXPW'(x2_r) * PXPW'(c2_r);
      y1_r3     <= y1_r;
      px_neg_r3 <= x2_neg_r2;
      y_neg_r3  <= y_neg_r2;
      ovf_p3    <= ovf_p2;
    end
  end

  // P4: round px and pick the output that bypasses the divider.
  logic [PXPW:0]   px_rnd;
  logic [PXFW-1:0] px_shf;
  logic            px_ovf;
  logic [PXW-1:0]  px_sat;

  assign px_rnd = (PXPW+1)'(pxp_r) + ((PXPW+1)'(1) << (TF-1));
  assign px_shf = PXFW'(px_rnd >> TF);
  assign px_ovf = |(px_shf >> IW);
  assign px_sat = px_ovf ? '1 : PXW'(px_shf);

  logic [OTHW-1:0] od_mag_r [ODL+1];
  logic            od_neg_r [ODL+1];
  logic            od_ovf_r [ODL+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      od_mag_r[0] <= tan_mode_r ? OTHW'(px_sat) : OTHW'(y1_r3);
      od_neg_r[0] <= tan_mode_r ? px_neg_r3 : y_neg_r3;
      od_ovf_r[0] <= ovf_p3 | (tan_mode_r & px_ovf);
      for (int k = 1; k <= ODL; k++) begin
        od_mag_r[k] <= od_mag_r[k-1];
        od_neg_r[k] <= od_neg_r[k-1];
        od_ovf_r[k] <= od_ovf_r[k-1];
      end
    end
  end

  // Output stage: saturate to the word range.
  function automatic logic [W:0] word_sat(input logic [IW-1:0] mag, input logic neg);
    logic          hi, over;
    logic [W-1:0]  v;
    hi = |(mag >> W);
    if (neg) begin
      over = hi || (mag[W-1] && (|mag[W-2:0]));
      v    = over ? {1'b1, {(W-1){1'b0}}} : (W'(0) - mag[W-1:0]);
    end else begin
      over = hi || mag[W-1];
      v    = over ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
    end
    return {over, v};
  endfunction

  logic [IW-1:0] fx_mag, fy_mag;
  logic          fx_neg, fy_neg;
  logic [W:0]    sx, sy;

  assign fx_mag = tan_mode_r ? IW'(od_mag_r[ODL]) : quo_mag;
  assign fx_neg = tan_mode_r ? od_neg_r[ODL] : quo_neg;
  assign fy_mag = tan_mode_r ? quo_mag : IW'(od_mag_r[ODL]);
  assign fy_neg = tan_mode_r ? quo_neg : od_neg_r[ODL];
  assign sx     = word_sat(fx_mag, fx_neg);
  assign sy     = word_sat(fy_mag, fy_neg);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_proj_x   <= $signed(sx[W-1:0]);
      out_proj_y   <= $signed(sy[W-1:0]);
      out_overflow <= od_ovf_r[ODL] | quo_ovf | sx[W] | sy[W];
    end
  end

  // A held output freezes the whole pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("pipeline moved while the output was stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("pipeline not empty after reset");

  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_valid |=> !valid_r[0])
    else $error("item appeared without an input");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !valid_r[LAST] |=> ($countones(valid_r) >= $past($countones(valid_r))))
    else $error("item lost inside the pipeline");

endmodule

`default_nettype wire

[design/stp_trig.sv]
// ----------------------------------------------------------------------------
// stp_trig
// Pipelined cosine and sine of a sign-magnitude angle: phase reduction in
// turns, quadrant split and 31 unrolled CORDIC rotation steps.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_trig #(
  parameter int AMW       = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [AMW-1:0]                        ang_mag,
  input  logic                                  ang_neg,
  output logic signed [stp_pkg::CORDIC_W-1:0]   cos_o,
  output logic signed [stp_pkg::CORDIC_W-1:0]   sin_o
);
  import stp_pkg::*;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam int PW     = AMW + 32;
  localparam int SUMW_R = PW + 1;
  localparam int SUMW   = (SUMW_R > FRAC_BITS + 32) ? SUMW_R : FRAC_BITS + 32;
  localparam int CW     = CORDIC_W;

  // Phase partial products.
  logic [PW-1:0] ph_hi_r, ph_lo_r;
  logic          neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_hi_r <= PW'(ang_mag) * PW'(INV_2PI_HI);
      ph_lo_r <= PW'(ang_mag) * PW'(INV_2PI_LO);
      neg_r   <= ang_neg;
    end
  end

  // Phase in turns, quadrant and residual.
  logic [SUMW-1:0]    sum;
  logic [31:0]        ph, ph_s, sh;
  logic signed [30:0] res;
  quad_t              quad_r2;
  logic signed [30:0] res_r;

  assign sum  = SUMW'(ph_hi_r) + SUMW'(ph_lo_r >> 32);
  assign ph   = sum[FRAC_BITS +: 32];
  assign ph_s = neg_r ? (32'd0 - ph) : ph;
  assign sh   = ph_s + 32'h2000_0000;
  assign res  = $signed({1'b0, sh[29:0]}) - 31'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r2 <= quad_t'(sh[31:30]);
      res_r   <= res;
    end
  end

  // Residual to radians.
  logic signed [62:0] rp_r;
  quad_t              quad_r3;

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r    <= 63'(res_r) * 63'(HALF_PI_Q30);
      quad_r3 <= quad_r2;
    end
  end

  logic signed [62:0]   zt;
  logic signed [CW-1:0] z_r;
  quad_t                quad_r4;

  assign zt = (rp_r + 63'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      z_r     <= CW'(zt);
      quad_r4 <= quad_r3;
    end
  end

  // Rotation steps, one register stage each.
  logic signed [CW-1:0] cx_r [CORDIC_STEPS];
  logic signed [CW-1:0] cy_r [CORDIC_STEPS];
  logic signed [CW-1:0] cz_r [CORDIC_STEPS];
  quad_t                cq_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi, ang;
    quad_t                qi;

    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_r;
      assign qi = quad_r4;
    end else begin : g_next
      assign xi = cx_r[k-1];
      assign yi = cy_r[k-1];
      assign zi = cz_r[k-1];
      assign qi = cq_r[k-1];
    end

    assign ang = $signed(CW'(ATAN_TAB[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          cx_r[k] <= xi - (yi >>> k);
          cy_r[k] <= yi + (xi >>> k);
          cz_r[k] <= zi - ang;
        end else begin
          cx_r[k] <= xi + (yi >>> k);
          cy_r[k] <= yi - (xi >>> k);
          cz_r[k] <= zi + ang;
        end
        cq_r[k] <= qi;
      end
    end
  end

  // Quadrant map.
  logic signed [CW-1:0] fx, fy;
  assign fx = cx_r[CORDIC_STEPS-1];
  assign fy = cy_r[CORDIC_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      case (cq_r[CORDIC_STEPS-1])
        QUAD_0: begin
          cos_o <= fx;
          sin_o <= fy;
        end
        QUAD_1: begin
          cos_o <= -fy;
          sin_o <= fx;
        end
        QUAD_2: begin
          cos_o <= -fx;
          sin_o <= -fy;
        end
        default: begin
          cos_o <= fy;
          sin_o <= -fx;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/stp_div.sv]
// ----------------------------------------------------------------------------
// stp_div
// Pipelined rounding divider, one quotient bit per stage, giving
// round(n * 2^30 / d) in sign-magnitude with saturation and zero-divisor
// handling.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_div #(
  parameter int NMW = 38
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [NMW-1:0]                    num_mag,
  input  logic                              num_neg,
  input  logic [stp_pkg::TRIG_MAG_W-1:0]    den_mag,
  input  logic                              den_neg,
  output logic [stp_pkg::INNER_W-1:0]       quo_mag,
  output logic                              quo_neg,
  output logic                              quo_ovf
);
  import stp_pkg::*;

  localparam int DW   = TRIG_MAG_W;
  localparam int NUMW = NMW + TRIG_FRAC + 1;
  localparam int NUMX = (NUMW > INNER_W) ? NUMW : INNER_W + 1;
  localparam int HW   = NUMX - INNER_W;
  localparam int CMPW = (HW > DW) ? HW : DW;

  typedef struct packed {
    logic dz;
    logic big;
    logic nz;
    logic neg;
  } div_flag_t;

  logic [NUMX-1:0] num;
  logic [HW-1:0]   num_hi;
  logic            big;

  assign num    = (NUMX'(num_mag) << TRIG_FRAC) + NUMX'(den_mag >> 1);
  assign num_hi = num[NUMX-1:INNER_W];
  // A quotient of 2^62 or more is known before any bit is developed.
  assign big    = CMPW'(num_hi) >= CMPW'(den_mag);

  logic [INNER_W-1:0] lo_r   [INNER_W+1];
  logic [INNER_W-1:0] q_r    [INNER_W+1];
  logic [DW-1:0]      rem_r  [INNER_W+1];
  logic [DW-1:0]      dm_r   [INNER_W+1];
  div_flag_t          flg_r  [INNER_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r[0]      <= num[INNER_W-1:0];
      q_r[0]       <= '0;
      rem_r[0]     <= DW'(num_hi);
      dm_r[0]      <= den_mag;
      flg_r[0].dz  <= (den_mag == '0);
      flg_r[0].big <= big;
      flg_r[0].nz  <= (num_mag != '0);
      flg_r[0].neg <= num_neg ^ den_neg;
    end
  end

  for (genvar j = 1; j <= INNER_W; j++) begin : g_bit
    logic [DW:0] t, d;
    logic        ge;

    assign t  = {rem_r[j-1], lo_r[j-1][INNER_W-j]};
    assign d  = {1'b0, dm_r[j-1]};
    assign ge = (t >= d);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DW'(t - d) : DW'(t);
        q_r[j]   <= {q_r[j-1][INNER_W-2:0], ge};
        lo_r[j]  <= lo_r[j-1];
        dm_r[j]  <= dm_r[j-1];
        flg_r[j] <= flg_r[j-1];
      end
    end
  end

  div_flag_t f;
  assign f = flg_r[INNER_W];

  always_ff @(posedge clk) begin
    if (en) begin
      quo_neg <= f.neg;
      if (f.dz) begin
        quo_mag <= f.nz ? '1 : '0;
        quo_ovf <= 1'b1;
      end else if (f.big) begin
        quo_mag <= '1;
        quo_ovf <= 1'b1;
      end else begin
        quo_mag <= q_r[INNER_W];
        quo_ovf <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sine_tangent_projection_forward_tb.sv]
// ----------------------------------------------------------------------------
// sine_tangent_projection_forward_tb
// Checks the forward sine-tangent projection against a bit-exact predictor
// of its fixed-point CORDIC, multiply and divide steps, over several
// coefficient settings in both sine and tangent form, with random idling on
// both the input and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_tangent_projection_forward_tb;
  import stp_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int WORD_BITS = 32;
  localparam longint INNER_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INV_2PI = {INV_2PI_HI, INV_2PI_LO};
  localparam int HALF_PI_Q28 = 421657428;
  localparam int PI_Q28 = 843314856;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [WORD_BITS-1:0] lon;
    logic signed [WORD_BITS-1:0] lat;
  } geo_pt_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] px;
    logic signed [WORD_BITS-1:0] py;
    logic                        ovf;
  } map_pt_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [WORD_BITS-1:0] in_longitude;
  logic signed [WORD_BITS-1:0] in_latitude;
  logic out_valid;
  logic out_ready;
  logic signed [WORD_BITS-1:0] out_proj_x;
  logic signed [WORD_BITS-1:0] out_proj_y;
  logic out_overflow;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [WORD_BITS-2:0] cfg_wdata;

  // Shadow copy of the coefficient registers.
  logic [WORD_BITS-2:0] cx_shadow;
  logic [WORD_BITS-2:0] cy_shadow;
  logic [WORD_BITS-2:0] cp_shadow;
  bit                   tan_shadow;

  geo_pt_t pending_pts[$];
  map_pt_t expected_pts[$];
  bit      idle_on;
  int      feed_gap;
  int      drain_stall;
  int      points_sent;
  int      points_checked;
  int      mismatches;
  int      overflow_seen;
  int      settings_used;

  sine_tangent_projection_forward #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_longitude(in_longitude),
    .in_latitude(in_latitude),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_proj_x(out_proj_x),
    .out_proj_y(out_proj_y),
    .out_overflow(out_overflow),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_inner(logic [127:0] m, bit neg, inout bit ovf);
    if (m > 128'(INNER_LIM)) begin
      ovf = 1'b1;
      m = 128'(INNER_LIM);
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh, inout bit ovf);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return clamp_inner(p, (a < 0) != (b < 0), ovf);
  endfunction

  function automatic longint fx_div(longint n, longint d, inout bit ovf);
    logic [127:0] num;
    logic [127:0] dm;
    if (d == 0) begin
      ovf = 1'b1;
      return n > 0 ? INNER_LIM : (n < 0 ? -INNER_LIM : 64'sd0);
    end
    dm = {64'd0, mag64(d)};
    num = ({64'd0, mag64(n)} << TRIG_FRAC) + (dm >> 1);
    return clamp_inner(num / dm, (n < 0) != (d < 0), ovf);
  endfunction

  // Cosine and sine in Q2.30 of an angle in Q(.FRAC_BITS).
  function automatic void trig_of(longint ang, output longint cv, output longint sv);
    logic [127:0] prod;
    logic [31:0]  ph;
    logic [31:0]  sh;
    longint       r, z, x, y, dx, dy;
    prod = {64'd0, mag64(ang)} * {64'd0, INV_2PI};
    ph = prod[FRAC_BITS+32 +: 32];
    if (ang < 0) ph = -ph;
    sh = ph + 32'h2000_0000;
    r = longint'(sh[29:0]) - 64'sh2000_0000;
    z = (r * longint'(HALF_PI_Q30) + (64'sd1 <<< 29)) >>> 30;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    case (sh[31:30])
      2'd0: begin cv = x;  sv = y;  end
      2'd1: begin cv = -y; sv = x;  end
      2'd2: begin cv = -x; sv = -y; end
      default: begin cv = y; sv = -x; end
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] clamp_word(longint v, inout bit ovf);
    longint hi, lo;
    hi = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (WORD_BITS - 1));
    if (v > hi) begin v = hi; ovf = 1'b1; end
    if (v < lo) begin v = lo; ovf = 1'b1; end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic map_pt_t project_point(geo_pt_t g);
    map_pt_t m;
    bit      ovf;
    longint  lon, lat, cphi, sphi, c, s, x1, x2, phs, px, py, c2;
    ovf = 1'b0;
    lon = longint'(g.lon);
    lat = longint'(g.lat);
    trig_of(lat, cphi, sphi);
    x1 = fx_mul(longint'(cx_shadow), lon, FRAC_BITS, ovf);
    x2 = fx_mul(x1, cphi, TRIG_FRAC, ovf);
    phs = fx_mul(longint'(cp_shadow), lat, FRAC_BITS, ovf);
    trig_of(phs, c, s);
    if (tan_shadow) begin
      c2 = fx_mul(c, c, TRIG_FRAC, ovf);
      px = fx_mul(x2, c2, TRIG_FRAC, ovf);
      py = fx_div(fx_mul(longint'(cy_shadow), s, TRIG_FRAC, ovf), c, ovf);
    end else begin
      px = fx_div(x2, c, ovf);
      py = fx_mul(longint'(cy_shadow), s, TRIG_FRAC, ovf);
    end
    m.px = clamp_word(px, ovf);
    m.py = clamp_word(py, ovf);
    m.ovf = ovf;
    return m;
  endfunction

  // Sender: presents queued items, with a random gap after each one while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pts.push_back(project_point('{lon: in_longitude, lat: in_latitude}));
        points_sent <= points_sent + 1;
      end
      if (in_valid && !in_ready) begin
        // Hold the item until it is taken.
      end else if (feed_gap > 0) begin
        in_valid <= 1'b0;
        feed_gap <= feed_gap - 1;
      end else if (pending_pts.size() > 0) begin
        geo_pt_t g;
        g = pending_pts.pop_front();
        in_longitude <= g.lon;
        in_latitude <= g.lat;
        in_valid <= 1'b1;
        feed_gap <= idle_on ? $urandom_range(0, 19) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result and, while idling is on, stalls at random after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      drain_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pts.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result x=%0d y=%0d ovf=%0b", out_proj_x, out_proj_y,
                     out_overflow);
        end else begin
          map_pt_t e;
          e = expected_pts.pop_front();
          points_checked <= points_checked + 1;
          if (out_overflow) overflow_seen <= overflow_seen + 1;
          if (e.px !== out_proj_x || e.py !== out_proj_y || e.ovf !== out_overflow) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch on result %0d: expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                       points_checked, e.px, e.py, e.ovf, out_proj_x, out_proj_y,
                       out_overflow);
          end
        end
      end
      if (drain_stall > 0) begin
        out_ready <= 1'b0;
        drain_stall <= drain_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready && idle_on)
          drain_stall <= $urandom_range(0, 19);
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pts.size() != 0 || in_valid || expected_pts.size() != 0);
    // Every accepted item has been checked by now; the settle wait only adds margin.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [WORD_BITS-2:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_X_SCALE:   cx_shadow = val;
      REG_Y_SCALE:   cy_shadow = val;
      REG_LAT_SCALE: cp_shadow = val;
      REG_TAN_MODE:  tan_shadow = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [WORD_BITS-2:0] cx, logic [WORD_BITS-2:0] cy,
                               logic [WORD_BITS-2:0] cp, bit tmode);
    wait_drained();
    write_reg(REG_X_SCALE, cx);
    write_reg(REG_Y_SCALE, cy);
    write_reg(REG_LAT_SCALE, cp);
    write_reg(REG_TAN_MODE, {30'd0, tmode});
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_on = ($urandom_range(0, 3) != 0);
    settings_used++;
  endtask

  task automatic queue_point(int lon, int lat);
    pending_pts.push_back('{lon: lon, lat: lat});
  endtask

  task automatic queue_random(int n);
    int sel, lon, lat;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      lon = int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
      lat = int'($urandom_range(0, 2 * HALF_PI_Q28)) - HALF_PI_Q28;
      if (sel >= 6 && sel <= 7) begin
        lon = $urandom;
        lat = $urandom;
      end else if (sel == 8) begin
        lat = ($urandom_range(0, 1) ? HALF_PI_Q28 : -HALF_PI_Q28) +
              int'($urandom_range(0, 64)) - 32;
      end else if (sel == 9) begin
        lon = $urandom;
      end
      queue_point(lon, lat);
    end
  endtask

  initial begin
    int   zero_cos_lat[$];
    longint cv, sv;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_longitude <= '0;
    in_latitude <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_X_SCALE;
    cfg_wdata <= '0;
    cx_shadow = 31'(X_SCALE_RST);
    cy_shadow = 31'(Y_SCALE_RST);
    cp_shadow = 31'(LAT_SCALE_RST);
    tan_shadow = 1'b0;
    idle_on = 1'b1;
    points_sent = 0;
    points_checked = 0;
    mismatches = 0;
    overflow_seen = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Latitudes near the poles whose CORDIC cosine is exactly zero at unit scale.
    for (int d = -200; d <= 200; d++) begin
      trig_of(longint'(HALF_PI_Q28 + d), cv, sv);
      if (cv == 0) begin
        zero_cos_lat.push_back(HALF_PI_Q28 + d);
        zero_cos_lat.push_back(-(HALF_PI_Q28 + d));
      end
    end
    if (zero_cos_lat.size() == 0) zero_cos_lat.push_back(HALF_PI_Q28);

    // Reset coefficients, sine form: field extremes, equator, poles, wrap.
    queue_point(0, 0);
    queue_point(32'h7FFF_FFFF, 0);
    queue_point(32'h8000_0000, 0);
    queue_point(PI_Q28, HALF_PI_Q28);
    queue_point(-PI_Q28, -HALF_PI_Q28);
    queue_point(PI_Q28, 32'h7FFF_FFFF);
    queue_point(-PI_Q28, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000);
    queue_point(-1, -1);
    queue_point(1, 1);
    queue_point(PI_Q28 / 2, HALF_PI_Q28 / 2);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555);
    queue_point(PI_Q28, 3 * HALF_PI_Q28);
    queue_random(130);

    apply_setting(31'(X_SCALE_RST), 31'(Y_SCALE_RST), 31'(LAT_SCALE_RST), 1'b1);
    queue_point(PI_Q28, HALF_PI_Q28);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(130);

    // Unit coefficients so that a pole gives a zero cosine divisor.
    apply_setting(31'(1 << FRAC_BITS), 31'(1 << FRAC_BITS), 31'(1 << FRAC_BITS), 1'b0);
    idle_on = 1'b0;
    foreach (zero_cos_lat[k]) queue_point(PI_Q28, zero_cos_lat[k]);
    queue_point(0, zero_cos_lat[0]);
    queue_random(130);
    apply_setting(31'(1 << FRAC_BITS), 31'(1 << FRAC_BITS), 31'(1 << FRAC_BITS), 1'b1);
    foreach (zero_cos_lat[k]) queue_point(PI_Q28, zero_cos_lat[k]);
    queue_point(0, 0);
    queue_random(130);

    apply_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    queue_random(110);
    apply_setting(31'd0, 31'd0, 31'd0, 1'b0);
    queue_random(60);
    apply_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    queue_random(80);

    for (int p = 0; p < 3; p++) begin
      apply_setting(31'($urandom), 31'($urandom_range(0, 32'h3FFF_FFFF)),
                    31'($urandom_range(0, 32'h2000_0000)), 1'($urandom_range(0, 1)));
      queue_random(90);
    end
    wait_drained();

    $display("Checked %0d of %0d items over %0d coefficient settings, %0d with overflow.",
             points_checked, points_sent, settings_used, overflow_seen);
    $display("Both sine and tangent forms ran, including zero-cosine poles and wrapped angles.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out with %0d results outstanding.", expected_pts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
